FILE: design/grid_dda_ray_caster_top_defines.svh
// Assertion macros for the grid ray caster.
`ifndef GRID_DDA_RAY_CASTER_TOP_DEFINES_SVH
`define GRID_DDA_RAY_CASTER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define GDRC_ASSERT_NOW(name, pre, post) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("%m: check failed");

// Next-cycle implication, sampled on clk_i, off during reset.
`define GDRC_ASSERT_NEXT(name, pre, post) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("%m: check failed");

`endif

FILE: design/gdrc_pkg.sv
// Shared types, constants and the sine table builder for the grid ray caster.
package gdrc_pkg;

  localparam int SINE_ENTRIES = 256;
  localparam int SINE_BITS    = 8;
  localparam int IDX_W        = SINE_BITS + 1;
  localparam int MAG_W        = 16;
  localparam int DIR_W        = 17;
  localparam int POS_W        = 16;
  localparam int FRAC_W       = 11;
  localparam int CELL_W       = 5;
  localparam int KIND_W       = 3;
  localparam int DIST_W       = 17;
  localparam int RECIP_W      = 27;
  localparam int SIDE_W       = 48;
  localparam int MPOS_W       = 8;
  localparam int SEAM_W       = 26;

  localparam logic [DIST_W-1:0] DEPTH_RST = 17'd32768;
  localparam logic [KIND_W-1:0] KIND_FLOOR = 3'd0;

  localparam longint SeamOne = 64'd1 << SEAM_W;
  localparam logic [SEAM_W-1:0] SEAM_LO = SEAM_W'((3 * SeamOne + 99) / 100);
  localparam logic [SEAM_W-1:0] SEAM_HI = SEAM_W'((97 * SeamOne) / 100);

  localparam longint Q30_A1 = 64'sd1686629713;
  localparam longint Q30_A3 = -64'sd693598668;
  localparam longint Q30_A5 = 64'sd85569306;
  localparam longint Q30_A7 = -64'sd5026995;
  localparam longint Q30_A9 = 64'sd172272;

  typedef struct packed {
    logic                     cast;
    logic                     wr_ok;
    logic [POS_W-1:0]         pos_x;
    logic [POS_W-1:0]         pos_y;
    logic signed [DIR_W-1:0]  dir_x;
    logic signed [DIR_W-1:0]  dir_y;
    logic [CELL_W-1:0]        col;
    logic [CELL_W-1:0]        row;
    logic [KIND_W-1:0]        kind;
  } q_item_t;

  // Q30 product truncated toward zero.
  function automatic longint qmul30(longint a, longint b);
    logic   neg;
    longint ma;
    longint mb;
    neg = (a < 0) != (b < 0);
    ma  = (a < 0) ? -a : a;
    mb  = (b < 0) ? -b : b;
    return neg ? -((ma * mb) >>> 30) : ((ma * mb) >>> 30);
  endfunction

  // Quarter-wave entry in Q15, evaluated at elaboration only.
  function automatic logic [MAG_W-1:0] sine_entry(int i);
    longint x;
    longint x2;
    longint s;
    longint r;
    if (i >= SINE_ENTRIES) return 16'd32768;
    x  = (longint'(i) <<< 30) / SINE_ENTRIES;
    x2 = qmul30(x, x);
    s  = Q30_A9;
    s  = Q30_A7 + qmul30(x2, s);
    s  = Q30_A5 + qmul30(x2, s);
    s  = Q30_A3 + qmul30(x2, s);
    s  = Q30_A1 + qmul30(x2, s);
    r  = qmul30(x, s);
    if (r < 0) return '0;
    r = (r + 16384) >>> 15;
    return (r > 32768) ? 16'd32768 : MAG_W'(r);
  endfunction

endpackage

FILE: design/gdrc_front.sv
// Front end: classify each item and look up the ray direction.
module gdrc_front #(
  parameter int MAP_W = 32,
  parameter int MAP_H = 32
) (
  input  logic                          mode_i,
  input  logic [gdrc_pkg::POS_W-1:0]    pos_x_i,
  input  logic [gdrc_pkg::POS_W-1:0]    pos_y_i,
  input  logic [gdrc_pkg::POS_W-1:0]    ray_angle_i,
  input  logic [gdrc_pkg::CELL_W-1:0]   cell_col_i,
  input  logic [gdrc_pkg::CELL_W-1:0]   cell_row_i,
  input  logic [gdrc_pkg::KIND_W-1:0]   cell_kind_i,
  output gdrc_pkg::q_item_t             item_o
);
  import gdrc_pkg::*;

  logic [MAG_W-1:0]        sine_tbl [SINE_ENTRIES+1];
  logic [POS_W-1:0]        ang [2];
  logic signed [DIR_W-1:0] dir [2];

  for (genvar g = 0; g <= SINE_ENTRIES; g++) begin : g_tbl
    assign sine_tbl[g] = sine_entry(g);
  end

  assign ang[0] = ray_angle_i;
  assign ang[1] = POS_W'(ray_angle_i + 16'd16384);

  // Mirror the phase in odd quadrants, negate in the lower half turn.
  for (genvar k = 0; k < 2; k++) begin : g_axis
    logic [SINE_BITS-1:0] idx;
    logic [IDX_W-1:0]     ridx;
    logic [MAG_W-1:0]     mag;
    assign idx  = ang[k][13 -: SINE_BITS];
    assign ridx = ang[k][14] ? IDX_W'(SINE_ENTRIES - int'(idx)) : {1'b0, idx};
    assign mag  = sine_tbl[ridx];
    assign dir[k] = ang[k][15] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  end

  always_comb begin
    item_o.cast  = mode_i;
    item_o.wr_ok = (int'(cell_col_i) < MAP_W) && (int'(cell_row_i) < MAP_H);
    item_o.pos_x = pos_x_i;
    item_o.pos_y = pos_y_i;
    item_o.dir_x = dir[0];
    item_o.dir_y = dir[1];
    item_o.col   = cell_col_i;
    item_o.row   = cell_row_i;
    item_o.kind  = cell_kind_i;
  end

endmodule

FILE: design/gdrc_queue.sv
// Two-entry queue between front and back.
module gdrc_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  gdrc_pkg::q_item_t item_i,
  input  logic              pop_i,
  output gdrc_pkg::q_item_t item_o,
  output logic              full_o,
  output logic              empty_o
);
  import gdrc_pkg::*;

  q_item_t    slot_q [2];
  logic       wr_q;
  logic       rd_q;
  logic [1:0] cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_q] <= item_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i)  rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

  assign item_o  = slot_q[rd_q];
  assign full_o  = cnt_q[1];
  assign empty_o = (cnt_q == 2'd0);

endmodule

FILE: design/gdrc_div.sv
// Radix-2 restoring divider: quotient of 2^26 by a 16-bit magnitude.
module gdrc_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [gdrc_pkg::MAG_W-1:0]    divisor_i,
  output logic                          busy_o,
  output logic [gdrc_pkg::RECIP_W-1:0]  quot_o
);
  import gdrc_pkg::*;

  logic                 busy_q;
  logic [4:0]           cnt_q;
  logic [MAG_W-1:0]     dvs_q;
  logic [MAG_W:0]       rem_q;
  logic [MAG_W:0]       rem_sh;
  logic                 fit;
  logic [RECIP_W-1:0]   quot_q;

  assign rem_sh = {rem_q[MAG_W-1:0], cnt_q == 5'(RECIP_W - 1)};
  assign fit    = rem_sh >= {1'b0, dvs_q};

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvs_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q  <= fit ? rem_sh - {1'b0, dvs_q} : rem_sh;
      quot_q <= {quot_q[RECIP_W-2:0], fit};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= 5'(RECIP_W - 1);
    end else if (busy_q) begin
      if (cnt_q == 5'd0) busy_q <= 1'b0;
      cnt_q <= cnt_q - 5'd1;
    end
  end

  assign busy_o = busy_q;
  assign quot_o = quot_q;

endmodule

FILE: design/gdrc_back.sv
// Back end: tile store, grid walk, distance and seam, result register.
module gdrc_back #(
  parameter int MAP_W = 32,
  parameter int MAP_H = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  gdrc_pkg::q_item_t            item_i,
  input  logic                         empty_i,
  output logic                         pop_o,
  output logic                         clearing_o,
  input  logic [gdrc_pkg::DIST_W-1:0]  max_depth_i,
  input  logic                         out_stall_i,
  output logic                         out_valid_o,
  output logic [gdrc_pkg::DIST_W-1:0]  hit_distance_o,
  output logic [gdrc_pkg::KIND_W-1:0]  hit_kind_o,
  output logic                         hit_on_y_side_o,
  output logic                         near_seam_o
);
  import gdrc_pkg::*;

  localparam int CELLS  = MAP_W * MAP_H;
  localparam int ADDR_W = $clog2(CELLS);

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_DIV   = 4'd2;
  localparam logic [3:0] S_SETUP = 4'd3;
  localparam logic [3:0] S_STEP  = 4'd4;
  localparam logic [3:0] S_RD    = 4'd5;
  localparam logic [3:0] S_CHK   = 4'd6;
  localparam logic [3:0] S_DIST  = 4'd7;
  localparam logic [3:0] S_MUL   = 4'd8;
  localparam logic [3:0] S_SEAM  = 4'd9;
  localparam logic [3:0] S_OUT   = 4'd10;

  logic [3:0]               state_q, state_d;
  logic [ADDR_W-1:0]        clr_q;

  logic [KIND_W-1:0]        tiles [CELLS];
  logic [KIND_W-1:0]        rdata_q;
  logic                     mem_we, mem_re;
  logic [ADDR_W-1:0]        waddr, raddr;
  logic [KIND_W-1:0]        wdata;

  logic [POS_W-1:0]         px_q, py_q;
  logic signed [DIR_W-1:0]  dx_q, dy_q;
  logic                     infx, infy, negx, negy;
  logic                     start;
  logic                     busy_x, busy_y;
  logic [RECIP_W-1:0]       quot_x, quot_y, rx, ry;
  logic [SIDE_W-1:0]        side_x_q, side_y_q, stride_x, stride_y;
  logic [FRAC_W:0]          fac_x, fac_y;
  logic [FRAC_W+RECIP_W:0]  init_x, init_y;
  logic signed [MPOS_W-1:0] mx_q, my_q;
  logic                     yside_q, step_x, off_map;
  logic [SIDE_W-1:0]        prev_side;
  logic [SIDE_W-12:0]       perp_full;
  logic [DIST_W-1:0]        perp_q;
  logic [KIND_W-1:0]        kind_q;
  logic [SEAM_W-1:0]        prod_q, seam_f;
  logic signed [DIR_W+DIST_W:0] prod;
  logic                     seam_q;
  logic                     out_valid_q, out_load;

  // Tile store, cleared by a sweep after reset.
  assign pop_o  = (state_q == S_IDLE) && !empty_i;
  assign start  = pop_o && item_i.cast;
  assign mem_we = (state_q == S_CLR) || (pop_o && !item_i.cast && item_i.wr_ok);
  assign waddr  = (state_q == S_CLR) ? clr_q
                : ADDR_W'(int'(item_i.row) * MAP_W + int'(item_i.col));
  assign wdata  = (state_q == S_CLR) ? KIND_FLOOR : item_i.kind;
  assign raddr  = ADDR_W'(int'(my_q) * MAP_W + int'(mx_q));

  always_ff @(posedge clk_i) begin
    if (mem_we) tiles[waddr] <= wdata;
    if (mem_re) rdata_q <= tiles[raddr];
  end

  // Reciprocal step lengths, one divider per axis.
  gdrc_div u_div_x (
    .clk_i, .rst_ni, .start_i(start),
    .divisor_i(MAG_W'(item_i.dir_x < 0 ? -item_i.dir_x : item_i.dir_x)),
    .busy_o(busy_x), .quot_o(quot_x)
  );
  gdrc_div u_div_y (
    .clk_i, .rst_ni, .start_i(start),
    .divisor_i(MAG_W'(item_i.dir_y < 0 ? -item_i.dir_y : item_i.dir_y)),
    .busy_o(busy_y), .quot_o(quot_y)
  );

  assign infx     = (dx_q == '0);
  assign infy     = (dy_q == '0);
  assign negx     = dx_q < 0;
  assign negy     = dy_q < 0;
  assign rx       = infx ? '0 : quot_x;
  assign ry       = infy ? '0 : quot_y;
  assign stride_x = SIDE_W'({rx, 11'b0});
  assign stride_y = SIDE_W'({ry, 11'b0});
  assign fac_x    = negx ? {1'b0, px_q[FRAC_W-1:0]} : 12'd2048 - {1'b0, px_q[FRAC_W-1:0]};
  assign fac_y    = negy ? {1'b0, py_q[FRAC_W-1:0]} : 12'd2048 - {1'b0, py_q[FRAC_W-1:0]};
  assign init_x   = fac_x * rx;
  assign init_y   = fac_y * ry;

  // Equal side distances step along y.
  assign step_x   = !infx && (infy || side_x_q < side_y_q);
  assign off_map  = (mx_q < 0) || (int'(mx_q) >= MAP_W) || (my_q < 0) || (int'(my_q) >= MAP_H);
  assign mem_re   = (state_q == S_RD) && !off_map;

  assign prev_side = yside_q ? side_y_q - stride_y : side_x_q - stride_x;
  assign perp_full = prev_side[SIDE_W-1:11];
  assign prod      = $signed({1'b0, perp_q}) * (yside_q ? dx_q : dy_q);
  assign seam_f    = {(yside_q ? px_q[FRAC_W-1:0] : py_q[FRAC_W-1:0]), 15'b0} + prod_q;
  assign out_load  = (state_q == S_OUT) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLR:   if (clr_q == ADDR_W'(CELLS - 1)) state_d = S_IDLE;
      S_IDLE:  if (start) state_d = S_DIV;
      S_DIV:   if (!busy_x && !busy_y) state_d = S_SETUP;
      S_SETUP: state_d = S_STEP;
      S_STEP:  state_d = S_RD;
      S_RD:    state_d = off_map ? S_OUT : S_CHK;
      S_CHK:   state_d = (rdata_q != KIND_FLOOR) ? S_DIST : S_STEP;
      S_DIST:  state_d = S_MUL;
      S_MUL:   state_d = S_SEAM;
      S_SEAM:  state_d = S_OUT;
      S_OUT:   if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      px_q <= item_i.pos_x;
      py_q <= item_i.pos_y;
      dx_q <= item_i.dir_x;
      dy_q <= item_i.dir_y;
      mx_q <= MPOS_W'(item_i.pos_x[POS_W-1:FRAC_W]);
      my_q <= MPOS_W'(item_i.pos_y[POS_W-1:FRAC_W]);
    end
    if (state_q == S_SETUP) begin
      side_x_q <= SIDE_W'(init_x);
      side_y_q <= SIDE_W'(init_y);
    end
    if (state_q == S_STEP) begin
      yside_q <= !step_x;
      if (step_x) begin
        side_x_q <= side_x_q + stride_x;
        mx_q     <= negx ? mx_q - 8'sd1 : mx_q + 8'sd1;
      end else begin
        side_y_q <= side_y_q + stride_y;
        my_q     <= negy ? my_q - 8'sd1 : my_q + 8'sd1;
      end
    end
    if (state_q == S_RD && off_map) begin
      perp_q <= max_depth_i;
      kind_q <= KIND_FLOOR;
      seam_q <= 1'b0;
    end
    if (state_q == S_CHK) kind_q <= rdata_q;
    if (state_q == S_DIST) begin
      perp_q <= (perp_full > SIDE_W'(max_depth_i)) ? max_depth_i : DIST_W'(perp_full);
    end
    if (state_q == S_MUL)  prod_q <= prod[SEAM_W-1:0];
    if (state_q == S_SEAM) seam_q <= (seam_f < SEAM_LO) || (seam_f > SEAM_HI);
    if (out_load) begin
      hit_distance_o  <= perp_q;
      hit_kind_o      <= kind_q;
      hit_on_y_side_o <= yside_q;
      near_seam_o     <= seam_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLR) clr_q <= clr_q + 1'b1;
      if (out_load)         out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  assign clearing_o  = (state_q == S_CLR);
  assign out_valid_o = out_valid_q;

endmodule

FILE: design/grid_dda_ray_caster_top.sv
// Grid DDA ray caster top level: tile map writes and ray casts over one input channel.
// A cast runs the reciprocal dividers, then steps, reads and checks cells in turn until
// a wall or the map edge (distance and seam on a wall); out_stall_i can hold the load.
// A cell write is applied as it pops in the back end; items run one at a time there, the next
// popping the cycle after a result loads, and the queue holds two items ahead of it.
// After reset the tile store is swept to floor cell by cell, input stalled meanwhile;
// max_depth resets to 32768.
`include "grid_dda_ray_caster_top_defines.svh"

module grid_dda_ray_caster_top #(
  parameter int MAP_W = 32,
  parameter int MAP_H = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input items
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          mode_i,
  input  logic [gdrc_pkg::POS_W-1:0]    pos_x_i,
  input  logic [gdrc_pkg::POS_W-1:0]    pos_y_i,
  input  logic [gdrc_pkg::POS_W-1:0]    ray_angle_i,
  input  logic [gdrc_pkg::CELL_W-1:0]   cell_col_i,
  input  logic [gdrc_pkg::CELL_W-1:0]   cell_row_i,
  input  logic [gdrc_pkg::KIND_W-1:0]   cell_kind_i,
  // result items
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [gdrc_pkg::DIST_W-1:0]   hit_distance_o,
  output logic [gdrc_pkg::KIND_W-1:0]   hit_kind_o,
  output logic                          hit_on_y_side_o,
  output logic                          near_seam_o,
  // max_depth register write
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [gdrc_pkg::DIST_W-1:0]   cfg_max_depth_i
);
  import gdrc_pkg::*;

  q_item_t            front_item, queue_item;
  logic               push, pop, full, empty, clearing;
  logic [DIST_W-1:0]  max_depth_q;

  // Register writes always complete; hold max_depth otherwise.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_depth_q <= DEPTH_RST;
    end else if (cfg_valid_i) begin
      max_depth_q <= cfg_max_depth_i;
    end
  end

  // Stall while the queue is full or the tile store is being swept.
  assign in_stall_o = full || clearing;
  assign push       = in_valid_i && !in_stall_o;

  // Front: classify the item and look up sine and cosine of the ray.
  gdrc_front #(.MAP_W(MAP_W), .MAP_H(MAP_H)) u_front (
    .mode_i, .pos_x_i, .pos_y_i, .ray_angle_i,
    .cell_col_i, .cell_row_i, .cell_kind_i,
    .item_o(front_item)
  );

  // Queue: lets the front take items while the back walks a ray.
  gdrc_queue u_queue (
    .clk_i, .rst_ni,
    .push_i(push), .item_i(front_item),
    .pop_i(pop), .item_o(queue_item),
    .full_o(full), .empty_o(empty)
  );

  // Back: apply cell writes, walk rays, hold the result until taken.
  gdrc_back #(.MAP_W(MAP_W), .MAP_H(MAP_H)) u_back (
    .clk_i, .rst_ni,
    .item_i(queue_item), .empty_i(empty), .pop_o(pop), .clearing_o(clearing),
    .max_depth_i(max_depth_q),
    .out_stall_i, .out_valid_o,
    .hit_distance_o, .hit_kind_o, .hit_on_y_side_o, .near_seam_o
  );

  // No item enters during the clearing sweep.
  `GDRC_ASSERT_NOW(a_no_push_clearing, clearing, !push)
  // An escaped ray never reports a seam.
  `GDRC_ASSERT_NOW(a_escape_no_seam, out_valid_o && (hit_kind_o == KIND_FLOOR), !near_seam_o)
  // The queue never pops while empty.
  `GDRC_ASSERT_NOW(a_pop_nonempty, pop, !empty)

endmodule

FILE: bench/testbench.sv
// Self-checking testbench for the grid DDA ray caster: directed, config, random and stall tests.
`timescale 1ns / 1ps

module testbench;
  import gdrc_pkg::*;

  localparam int GRID_W    = 32;
  localparam int GRID_H    = 32;
  localparam int QUARTER   = 256;
  localparam int MAX_CYC   = 3000000;
  localparam bit MODE_CELL = 1'b0;
  localparam bit MODE_CAST = 1'b1;

  typedef struct {
    logic [DIST_W-1:0] distance;
    logic [KIND_W-1:0] kind;
    logic              y_side;
    logic              seam;
  } hit_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic mode_i = 1'b0;
  logic [POS_W-1:0] pos_x_i = '0;
  logic [POS_W-1:0] pos_y_i = '0;
  logic [POS_W-1:0] ray_angle_i = '0;
  logic [CELL_W-1:0] cell_col_i = '0;
  logic [CELL_W-1:0] cell_row_i = '0;
  logic [KIND_W-1:0] cell_kind_i = '0;
  logic out_stall_i = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic [DIST_W-1:0] cfg_max_depth_i = '0;
  logic in_stall_o, out_valid_o, hit_on_y_side_o, near_seam_o, cfg_ready_o;
  logic [DIST_W-1:0] hit_distance_o;
  logic [KIND_W-1:0] hit_kind_o;

  // Predictor state: own copy of the tile map, the depth clamp and the sine table.
  logic [KIND_W-1:0] tiles [GRID_W*GRID_H];
  logic [DIST_W-1:0] depth_clamp = DEPTH_RST;
  longint            sine_tab [QUARTER+1];
  hit_t              pending_hits [$];

  int  mismatches = 0;
  int  cycles = 0;
  bit  idle_en = 1'b1;    // random gaps on both sides when set
  int  hold_cycles = 0;   // one-off long receiver stall, consumed by the receiver

  grid_dda_ray_caster_top uut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Give up well past the slowest legal run.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= MAX_CYC) begin
      $display("timeout after %0d cycles", cycles);
      $display("testbench NOT OK");
      $finish;
    end
  end

  // Q30 product, truncated toward zero.
  function automatic longint mul_q30(longint a, longint b);
    longint pa, pb, p;
    pa = (a < 0) ? -a : a;
    pb = (b < 0) ? -b : b;
    p  = (pa * pb) >>> 30;
    return ((a < 0) != (b < 0)) ? -p : p;
  endfunction

  // Quarter-wave sine in Q15 by odd Taylor series, rounded and limited.
  function automatic longint quarter_sine_q15(int i);
    longint x, x2, acc, r;
    if (i >= QUARTER) return 32768;
    x   = (longint'(i) <<< 30) / QUARTER;
    x2  = mul_q30(x, x);
    acc = 172272;
    acc = -5026995 + mul_q30(x2, acc);
    acc = 85569306 + mul_q30(x2, acc);
    acc = -693598668 + mul_q30(x2, acc);
    acc = 1686629713 + mul_q30(x2, acc);
    r   = mul_q30(x, acc);
    if (r < 0) return 0;
    r = (r + 16384) >>> 15;
    return (r > 32768) ? 32768 : r;
  endfunction

  function automatic longint heading_sine(logic [15:0] a);
    longint m;
    int idx;
    idx = int'(a[13:6]);
    m = a[14] ? sine_tab[QUARTER - idx] : sine_tab[idx];
    return a[15] ? -m : m;
  endfunction

  // Step length and start side distance for one axis, 1/2^22 cell.
  function automatic void axis_init(input longint dir, input logic [15:0] pos,
                                    output bit inf, output int stp,
                                    output longint stride, output longint side);
    longint d, fr;
    fr     = longint'(pos[10:0]);
    inf    = (dir == 0);
    d      = inf ? 0 : (64'd67108864 / ((dir < 0) ? -dir : dir));
    stride = d <<< 11;
    stp    = (dir < 0) ? -1 : 1;
    side   = (dir < 0) ? fr * d : (2048 - fr) * d;
  endfunction

  // Walk the grid until a wall or the map edge.
  function automatic hit_t trace_ray(logic [15:0] px, logic [15:0] py, logic [15:0] ang);
    hit_t   h;
    longint dx, dy, stx, sty, sdx, sdy, perp, hitc, fr;
    bit     infx, infy, yside, gone;
    int     sx, sy, mx, my;
    logic [KIND_W-1:0] k;
    dx = heading_sine(ang);
    dy = heading_sine(ang + 16'd16384);
    mx = int'(px[15:11]);
    my = int'(py[15:11]);
    axis_init(dx, px, infx, sx, stx, sdx);
    axis_init(dy, py, infy, sy, sty, sdy);
    gone = 0;
    k = KIND_FLOOR;
    forever begin
      if (!infx && (infy || sdx < sdy)) begin
        sdx += stx; mx += sx; yside = 0;
      end else begin
        sdy += sty; my += sy; yside = 1;
      end
      if (mx < 0 || mx >= GRID_W || my < 0 || my >= GRID_H) begin
        gone = 1;
        break;
      end
      k = tiles[my*GRID_W + mx];
      if (k != KIND_FLOOR) break;
    end
    h.y_side = yside;
    if (gone) begin
      h.distance = depth_clamp;
      h.kind = KIND_FLOOR;
      h.seam = 0;
      return h;
    end
    perp = yside ? ((sdy - sty) >>> 11) : ((sdx - stx) >>> 11);
    if (perp > depth_clamp) perp = depth_clamp;
    hitc = yside ? ((longint'(px) <<< 15) + perp*dx) : ((longint'(py) <<< 15) + perp*dy);
    fr = hitc & ((64'd1 << 26) - 1);
    h.distance = DIST_W'(perp);
    h.kind = k;
    h.seam = (fr*100 < 3*(64'd1 << 26)) || (fr*100 > 97*(64'd1 << 26));
    return h;
  endfunction

  // Offer one item, hold it until taken, then predict from it.
  task automatic send_item(bit md, logic [15:0] px, logic [15:0] py, logic [15:0] ang,
                           logic [4:0] col, logic [4:0] row, logic [2:0] kind);
    int gap;
    gap = idle_en ? $urandom_range(10, 0) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    mode_i      <= md;
    pos_x_i     <= px;
    pos_y_i     <= py;
    ray_angle_i <= ang;
    cell_col_i  <= col;
    cell_row_i  <= row;
    cell_kind_i <= kind;
    do @(posedge clk_i); while (in_stall_o);
    if (md == MODE_CELL) tiles[row*GRID_W + col] = kind;
    else pending_hits.push_back(trace_ray(px, py, ang));
  endtask

  task automatic cast_ray(logic [15:0] px, logic [15:0] py, logic [15:0] ang);
    send_item(MODE_CAST, px, py, ang, 5'($urandom), 5'($urandom), 3'($urandom));
  endtask

  task automatic put_cell(logic [4:0] col, logic [4:0] row, logic [2:0] kind);
    send_item(MODE_CELL, 16'($urandom), 16'($urandom), 16'($urandom), col, row, kind);
  endtask

  // Drop valid and wait for every expected result, plus the write back end.
  task automatic drain;
    in_valid_i <= 1'b0;
    while (pending_hits.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic set_depth(logic [DIST_W-1:0] val);
    drain();
    cfg_valid_i     <= 1'b1;
    cfg_max_depth_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    depth_clamp = val;
  endtask

  // Result side: random stall per result, then compare with the oldest prediction.
  initial begin
    int n;
    hit_t e;
    forever begin
      n = idle_en ? $urandom_range(10, 0) : 0;
      if (hold_cycles > 0) begin
        n = hold_cycles;
        hold_cycles = 0;
      end
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      if (pending_hits.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result dist=%0d", hit_distance_o);
      end else begin
        e = pending_hits.pop_front();
        if (hit_distance_o !== e.distance || hit_kind_o !== e.kind ||
            hit_on_y_side_o !== e.y_side || near_seam_o !== e.seam) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp dist=%0d kind=%0d y=%0d seam=%0d got %0d %0d %0d %0d",
                     e.distance, e.kind, e.y_side, e.seam, hit_distance_o, hit_kind_o,
                     hit_on_y_side_o, near_seam_o);
        end
      end
    end
  end

  // Empty map, axis headings, corner positions, walls of every kind, viewer inside a wall.
  task automatic test_directed;
    cast_ray(16'd0, 16'd0, 16'd0);
    cast_ray(16'hFFFF, 16'hFFFF, 16'd16384);
    cast_ray(16'd1024, 16'd1024, 16'd32768);
    cast_ray(16'd0, 16'hFFFF, 16'd49152);
    cast_ray(16'd1024, 16'd1024, 16'd8192);       // diagonal: equal side distances
    put_cell(5'd0, 5'd0, 3'd1);
    put_cell(5'd31, 5'd31, 3'd7);
    put_cell(5'd31, 5'd0, 3'd2);
    put_cell(5'd0, 5'd31, 3'd3);
    for (int k = 4; k <= 6; k++) put_cell(5'(k + 10), 5'd16, 3'(k));
    cast_ray(16'd3072, 16'd3072, 16'd40960);      // towards (0,0)
    cast_ray(16'd61440, 16'd61440, 16'd8192);     // towards (31,31)
    cast_ray(16'd1024, 16'd1024, 16'hFFFF);
    cast_ray(16'd1024, 16'd1024, 16'd0);          // inside a wall: still steps
    cast_ray(16'd10240, 16'd33792, 16'd16384);    // along the row of walls
    put_cell(5'd0, 5'd0, 3'd0);
    put_cell(5'd31, 5'd31, 3'd0);
    cast_ray(16'd1024, 16'd1024, 16'd40960);
  endtask

  // Clamp extremes, including zero, with walls at several ranges.
  task automatic test_depth_settings;
    logic [DIST_W-1:0] vals [5];
    vals = '{17'd0, 17'd1, 17'd131071, 17'($urandom_range(131071, 1)), DEPTH_RST};
    foreach (vals[v]) begin
      set_depth(vals[v]);
      for (int i = 0; i < 12; i++) cast_ray(16'($urandom), 16'($urandom), 16'($urandom));
    end
  endtask

  // Mostly casts over a map that gets rebuilt now and then; idle stretches vary.
  task automatic test_random_scene;
    for (int i = 0; i < 1400; i++) begin
      if (i % 200 == 0) idle_en = ~idle_en;
      if (i % 350 == 0 && i > 0) set_depth(17'($urandom_range(131071, 1)));
      if ($urandom_range(99, 0) < 22)
        put_cell(5'($urandom), 5'($urandom),
                 ($urandom_range(3, 0) == 0) ? 3'd0 : 3'($urandom));
      else
        cast_ray(16'($urandom), 16'($urandom), 16'($urandom));
    end
    idle_en = 1'b1;
    drain();
  endtask

  // Hold the result side for a long stretch while casts keep coming, then pause fully.
  task automatic test_backpressure;
    drain();
    idle_en = 1'b0;
    hold_cycles = 800;
    for (int i = 0; i < 30; i++) cast_ray(16'($urandom), 16'($urandom), 16'($urandom));
    drain();
    idle_en = 1'b1;
    for (int i = 0; i < 20; i++) cast_ray(16'($urandom), 16'($urandom), 16'($urandom));
  endtask

  initial begin
    for (int i = 0; i <= QUARTER; i++) sine_tab[i] = quarter_sine_q15(i);
    foreach (tiles[i]) tiles[i] = KIND_FLOOR;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_depth_settings();
    test_random_scene();
    test_backpressure();
    drain();
    repeat (300) @(posedge clk_i);
    if (mismatches == 0 && pending_hits.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+design
design/gdrc_pkg.sv
design/gdrc_front.sv
design/gdrc_queue.sv
design/gdrc_div.sv
design/gdrc_back.sv
design/grid_dda_ray_caster_top.sv
bench/testbench.sv
